[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop at every rising edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Require cons on the edge after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/esd_pkg.sv]
// ----------------------------------------------------------------------------
// esd_pkg
// Types and character constants for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam logic [15:0] CH_BACKSLASH = 16'h005C;
    localparam logic [15:0] CH_X         = 16'h0078;
    localparam logic [15:0] CH_0         = 16'h0030;
    localparam logic [15:0] CH_7         = 16'h0037;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_BACKSLASH,
        MODE_HEX,
        MODE_OCT,
        MODE_PASS
    } mode_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_char;
        logic        out_valid;
        logic        out_last;
    } res_item_t;

    typedef struct packed {
        mode_t      mode;
        logic [1:0] digit_count;
        logic [8:0] digit_accumulator;
    } dec_state_t;

    typedef struct packed {
        res_item_t  first;
        res_item_t  second;
        logic [1:0] count;
    } dec_result_t;

endpackage

[hw/rtl/esd_decode.sv]
// ----------------------------------------------------------------------------
// esd_decode
// Single-word decode step: next decoder state and up to two result words.
// ----------------------------------------------------------------------------
module esd_decode
    import esd_pkg::*;
(
    input  in_item_t    item,
    input  dec_state_t  state,
    output dec_state_t  state_next,
    output dec_result_t result
);

    function automatic logic [15:0] sext8(input logic [8:0] acc);
        sext8 = {{8{acc[7]}}, acc[7:0]};
    endfunction

    logic [15:0] c;
    logic        hex_hit;
    logic [3:0]  hex_val;
    logic        oct_hit;
    logic        single_hit;
    logic [15:0] single_val;
    logic [8:0]  hex_acc;
    logic [8:0]  oct_acc;

    assign c       = item.code_unit;
    assign oct_hit = (c >= CH_0) && (c <= CH_7);
    assign hex_acc = {state.digit_accumulator[4:0], hex_val};
    assign oct_acc = {state.digit_accumulator[5:0], c[2:0]};

    always_comb
    begin
        hex_hit = 1'b1;
        hex_val = c[3:0];
        if (c >= 16'h0030 && c <= 16'h0039)
        begin
            hex_val = c[3:0];
        end
        else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046))
        begin
            hex_val = 4'(c[3:0] + 4'd9);
        end
        else
        begin
            hex_hit = 1'b0;
        end
    end

    always_comb
    begin
        single_hit = 1'b1;
        case (c)
            16'h0061: single_val = 16'd7;
            16'h0062: single_val = 16'd8;
            16'h0066: single_val = 16'd12;
            16'h006E: single_val = 16'd10;
            16'h0072: single_val = 16'd13;
            16'h0074: single_val = 16'd9;
            16'h0076: single_val = 16'd11;
            16'h005C: single_val = 16'd92;
            16'h0027: single_val = 16'd39;
            16'h0022: single_val = 16'd34;
            default:
            begin
                single_val = 16'd0;
                single_hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        logic        a_en;
        logic [15:0] a_ch;
        logic        b_en;
        logic        c_en;
        logic [15:0] c_ch;
        logic        plain;
        dec_state_t  s;

        a_en  = 1'b0;
        a_ch  = 16'd0;
        b_en  = 1'b0;
        c_en  = 1'b0;
        c_ch  = 16'd0;
        plain = 1'b0;
        s     = state;

        // mode step
        case (state.mode)
            MODE_BACKSLASH:
            begin
                if (single_hit)
                begin
                    a_en   = 1'b1;
                    a_ch   = single_val;
                    s.mode = MODE_NORMAL;
                end
                else if (c == CH_X)
                begin
                    s.mode              = MODE_HEX;
                    s.digit_count       = 2'd0;
                    s.digit_accumulator = 9'd0;
                end
                else if (oct_hit)
                begin
                    s.mode              = MODE_OCT;
                    s.digit_count       = 2'd1;
                    s.digit_accumulator = {6'd0, c[2:0]};
                end
                else
                begin
                    a_en   = 1'b1;
                    a_ch   = c;
                    s.mode = MODE_PASS;
                end
            end
            MODE_HEX:
            begin
                if (hex_hit && state.digit_count < 2'd2)
                begin
                    s.digit_accumulator = hex_acc;
                    s.digit_count       = 2'(state.digit_count + 2'd1);
                    if (s.digit_count == 2'd2)
                    begin
                        a_en   = 1'b1;
                        a_ch   = sext8(hex_acc);
                        s.mode = MODE_NORMAL;
                    end
                end
                else
                begin
                    a_en  = 1'b1;
                    a_ch  = sext8(state.digit_accumulator);
                    plain = 1'b1;
                end
            end
            MODE_OCT:
            begin
                if (oct_hit && state.digit_count < 2'd3)
                begin
                    s.digit_accumulator = oct_acc;
                    s.digit_count       = 2'(state.digit_count + 2'd1);
                    if (s.digit_count == 2'd3)
                    begin
                        a_en   = 1'b1;
                        a_ch   = sext8(oct_acc);
                        s.mode = MODE_NORMAL;
                    end
                end
                else
                begin
                    a_en  = 1'b1;
                    a_ch  = sext8(state.digit_accumulator);
                    plain = 1'b1;
                end
            end
            MODE_PASS:
            begin
                a_en = 1'b1;
                a_ch = c;
            end
            default:
            begin
                plain = 1'b1;
            end
        endcase

        // plain text handling of the current word
        if (plain)
        begin
            if (c == CH_BACKSLASH)
            begin
                s.mode = MODE_BACKSLASH;
            end
            else
            begin
                b_en   = 1'b1;
                s.mode = MODE_NORMAL;
            end
        end

        // string end: flush a pending numeric escape, clear state
        if (item.end_of_string)
        begin
            if (s.mode == MODE_HEX || s.mode == MODE_OCT)
            begin
                c_en = 1'b1;
                c_ch = sext8(s.digit_accumulator);
            end
            s.mode              = MODE_NORMAL;
            s.digit_count       = 2'd0;
            s.digit_accumulator = 9'd0;
        end

        // compact the candidates into two slots
        result.first  = '0;
        result.second = '0;
        if (a_en)
        begin
            result.first = '{out_char: a_ch, out_valid: 1'b1, out_last: 1'b0};
            if (b_en)
            begin
                result.second = '{out_char: c, out_valid: 1'b1, out_last: 1'b0};
            end
            else if (c_en)
            begin
                result.second = '{out_char: c_ch, out_valid: 1'b1, out_last: 1'b0};
            end
        end
        else if (b_en)
        begin
            result.first = '{out_char: c, out_valid: 1'b1, out_last: 1'b0};
            if (c_en)
            begin
                result.second = '{out_char: c_ch, out_valid: 1'b1, out_last: 1'b0};
            end
        end
        else if (c_en)
        begin
            result.first = '{out_char: c_ch, out_valid: 1'b1, out_last: 1'b0};
        end
        result.count = 2'({1'b0, a_en} + {1'b0, b_en} + {1'b0, c_en});

        if (item.end_of_string)
        begin
            if (result.count == 2'd0)
            begin
                // empty end marker
                result.count = 2'd1;
            end
            if (result.count == 2'd2)
            begin
                result.second.out_last = 1'b1;
            end
            else
            begin
                result.first.out_last = 1'b1;
            end
        end

        state_next = s;
    end

endmodule

[hw/rtl/escape_sequence_decoder.sv]
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Streaming C escape decoder: one 16-bit code unit in, zero to two
// decoded characters out, with an empty end marker where a string
// closes without output.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | word        | contents
//  --------+----------------------+-------------+--------------------------------
//  input   | in_valid / in_ready  | in_data     | code_unit, end_of_string
//  result  | res_valid / res_ready| res_data    | out_char, out_valid, out_last
//
// A code unit is decoded in the cycle it is accepted and its results are
// written into a two-word result buffer; res_data shows the head word.
// One input word per cycle while res_ready is high and each word yields at
// most one result; a word that yields two results holds off the next input
// until its first word drains; the result port drains one word per cycle.
// in_ready rises when the buffer will be empty after this cycle's drain.
// Reset returns the decoder to plain text mode and empties the buffer.
// A stalled result port holds the buffer and, while any word waits in it,
// the input.
//
module escape_sequence_decoder
    import esd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res_data
);

`include "assert_macros.svh"

    // decoder state
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_state_t  dec_state;
    dec_result_t dec_result;

    // result buffer: slot0 is the head
    res_item_t   slot0_reg;
    res_item_t   slot0_next;
    res_item_t   slot1_reg;
    res_item_t   slot1_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;

    logic        in_fire;
    logic        res_fire;

    esd_decode u_decode (
        .item       (in_data),
        .state      (state_reg),
        .state_next (dec_state),
        .result     (dec_result)
    );

    assign res_valid = (fill_reg != 2'd0);
    assign res_data  = slot0_reg;
    assign res_fire  = res_valid && res_ready;

    // accept only when the buffer is empty after this cycle's drain
    assign in_ready  = (fill_reg == 2'd0) || ((fill_reg == 2'd1) && res_ready);
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        fill_next  = fill_reg;
        if (in_fire)
        begin
            // load the decoded words over the drained buffer
            state_next = dec_state;
            slot0_next = dec_result.first;
            slot1_next = dec_result.second;
            fill_next  = dec_result.count;
        end
        else if (res_fire)
        begin
            // advance the second word to the head
            slot0_next = slot1_reg;
            fill_next  = 2'(fill_reg - 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{mode: MODE_NORMAL, digit_count: 2'd0, digit_accumulator: 9'd0};
            fill_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // the buffer never holds more than two words
    `ASSERT_ALWAYS(a_fill_bound, fill_reg != 2'd3, "result buffer over-filled")

    // an empty end marker always closes its string
    `ASSERT_ALWAYS(a_marker_last, !res_valid || res_data.out_valid || res_data.out_last,
        "empty end marker without last flag")

    // the head of a two-word pair never closes the string
    `ASSERT_ALWAYS(a_pair_head, (fill_reg != 2'd2) || !slot0_reg.out_last,
        "last flag on the first of two words")

    // a string end leaves a closing word at the tail of the buffer
    `ASSERT_NEXT(a_eos_last, in_fire && in_data.end_of_string,
        res_valid && ((fill_reg == 2'd1) ? slot0_reg.out_last : slot1_reg.out_last),
        "string end without a closing word")

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Escape sequence decoder testbench
// Drives strings of 16-bit code units through the decoder: a directed set of
// escape corner cases first, then random strings that are mostly
// well-formed escape sequences and partly raw noise. The result words are
// checked against a cycle-free decoding model under three flow-control
// regimes.
// ----------------------------------------------------------------------------
module testbench
    import esd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 11;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int WORDS_A_PHASE = 430;
    localparam int SETTLE_CYCLES = 8;

    // ------------------------------------------------------------------------
    // Decoding model and store of expected result words
    // ------------------------------------------------------------------------
    class decode_scoreboard;
        mode_t      mode;
        logic [1:0] digits;
        logic [8:0] acc;
        res_item_t  step_q[$];
        res_item_t  expected_q[$];
        int         mismatches;
        int         results_seen;

        function new();
            mode         = MODE_NORMAL;
            digits       = '0;
            acc          = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void emit(logic [15:0] ch, logic valid);
            res_item_t r;
            r.out_char  = ch;
            r.out_valid = valid;
            r.out_last  = 1'b0;
            step_q.push_back(r);
        endfunction

        // Numeric escapes keep the low byte and sign-extend it.
        function logic [15:0] escape_value();
            return {{8{acc[7]}}, acc[7:0]};
        endfunction

        function void plain_unit(logic [15:0] c);
            mode = MODE_NORMAL;
            if (c == CH_BACKSLASH)
                mode = MODE_BACKSLASH;
            else
                emit(c, 1'b1);
        endfunction

        // Work out the result words of one accepted input word.
        function void note_word(in_item_t w);
            logic [15:0] c;
            int          hv;
            c  = w.code_unit;
            hv = -1;
            step_q = {};
            case (mode)
                MODE_BACKSLASH:
                begin
                    mode = MODE_NORMAL;
                    case (c)
                        "a": emit(16'd7, 1'b1);
                        "b": emit(16'd8, 1'b1);
                        "f": emit(16'd12, 1'b1);
                        "n": emit(16'd10, 1'b1);
                        "r": emit(16'd13, 1'b1);
                        "t": emit(16'd9, 1'b1);
                        "v": emit(16'd11, 1'b1);
                        CH_BACKSLASH, "'", "\"": emit(c, 1'b1);
                        CH_X:
                        begin
                            mode   = MODE_HEX;
                            digits = '0;
                            acc    = '0;
                        end
                        default:
                        begin
                            if (c >= CH_0 && c <= CH_7)
                            begin
                                mode   = MODE_OCT;
                                digits = 2'd1;
                                acc    = {6'd0, c[2:0]};
                            end
                            else
                            begin
                                // unknown escape: drop the backslash, pass the rest
                                emit(c, 1'b1);
                                mode = MODE_PASS;
                            end
                        end
                    endcase
                end
                MODE_HEX:
                begin
                    if (c >= CH_0 && c <= "9")
                        hv = int'(c) - int'(CH_0);
                    else if (c >= "a" && c <= "f")
                        hv = int'(c) - int'("a") + 10;
                    else if (c >= "A" && c <= "F")
                        hv = int'(c) - int'("A") + 10;
                    if (hv >= 0 && digits < 2'd2)
                    begin
                        acc    = {acc[4:0], 4'(hv)};
                        digits = digits + 2'd1;
                        if (digits == 2'd2)
                        begin
                            emit(escape_value(), 1'b1);
                            mode = MODE_NORMAL;
                        end
                    end
                    else
                    begin
                        emit(escape_value(), 1'b1);
                        plain_unit(c);
                    end
                end
                MODE_OCT:
                begin
                    if (c >= CH_0 && c <= CH_7 && digits < 2'd3)
                    begin
                        acc    = {acc[5:0], c[2:0]};
                        digits = digits + 2'd1;
                        if (digits == 2'd3)
                        begin
                            emit(escape_value(), 1'b1);
                            mode = MODE_NORMAL;
                        end
                    end
                    else
                    begin
                        emit(escape_value(), 1'b1);
                        plain_unit(c);
                    end
                end
                MODE_PASS: emit(c, 1'b1);
                default:   plain_unit(c);
            endcase

            if (w.end_of_string)
            begin
                // flush a pending numeric escape, then close the string
                if (mode == MODE_HEX || mode == MODE_OCT)
                    emit(escape_value(), 1'b1);
                mode   = MODE_NORMAL;
                digits = '0;
                acc    = '0;
                if (step_q.size() == 0)
                    emit(16'h0000, 1'b0);
                step_q[step_q.size() - 1].out_last = 1'b1;
            end
            foreach (step_q[i])
                expected_q.push_back(step_q[i]);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one result word with the oldest expectation.
        task check_word(res_item_t got);
            res_item_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result word %h/%b/%b with nothing expected",
                                          got.out_char, got.out_valid, got.out_last));
                return;
            end
            want = expected_q.pop_front();
            if (got.out_char !== want.out_char)
                report_mismatch($sformatf("out_char %h, expected %h",
                                          got.out_char, want.out_char));
            if (got.out_valid !== want.out_valid)
                report_mismatch($sformatf("out_valid %b, expected %b",
                                          got.out_valid, want.out_valid));
            if (got.out_last !== want.out_last)
                report_mismatch($sformatf("out_last %b, expected %b",
                                          got.out_last, want.out_last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      res_valid;
    logic      res_ready;
    res_item_t res_data;

    decode_scoreboard board;
    in_item_t         text_q[$];
    int               tx_idle_pct;
    int               rx_idle_pct;
    int               words_sent;
    int               words_in;
    int               cycle_count;
    string            esc_letters;

    escape_sequence_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Receiver: drop ready at random, at the rate of the current phase
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        res_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. Results are
    // registered, so check a result before noting a word taken at the same
    // edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
                board.check_word(res_data);
            if (in_valid && in_ready)
            begin
                board.note_word(in_data);
                words_in++;
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Present one word at a falling edge and hold it until it is taken.
    // Valid stays high on return; the next call decides whether to drop it.
    task automatic send_word(in_item_t w);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        @(negedge clk);
    endtask

    // Hold the input until every expected result has come, then let the
    // block settle.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic void push_unit(logic [15:0] c);
        in_item_t w;
        w.code_unit     = c;
        w.end_of_string = 1'b0;
        text_q.push_back(w);
    endfunction

    // Mark the last queued word as end of string and send the lot.
    task automatic ship_string();
        text_q[text_q.size() - 1].end_of_string = 1'b1;
        foreach (text_q[i])
            send_word(text_q[i]);
        text_q = {};
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_unit(16'(s[i]));
        ship_string();
    endtask

    // Build one random string: mostly escape sequences with random content,
    // now and then raw 16-bit noise with stray string ends.
    task automatic send_random_string();
        int          n_tokens;
        int          hv;
        logic [15:0] ch;
        in_item_t    w;
        if ($urandom_range(9) == 0)
        begin
            n_tokens = $urandom_range(1, 8);
            for (int i = 0; i < n_tokens; i++)
            begin
                w.code_unit     = 16'($urandom);
                w.end_of_string = ($urandom_range(7) == 0);
                text_q.push_back(w);
            end
            ship_string();
            return;
        end
        n_tokens = $urandom_range(1, 6);
        for (int i = 0; i < n_tokens; i++)
        begin
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    if ($urandom_range(3) == 0)
                        ch = 16'($urandom);
                    else
                        ch = 16'($urandom_range(32, 126));
                    if (ch == CH_BACKSLASH)
                        ch = "A";
                    push_unit(ch);
                end
                3, 4:
                begin
                    push_unit(CH_BACKSLASH);
                    push_unit(16'(esc_letters[$urandom_range(esc_letters.len() - 1)]));
                end
                5:
                begin
                    push_unit(CH_BACKSLASH);
                    push_unit(CH_X);
                    repeat ($urandom_range(0, 3))
                    begin
                        hv = $urandom_range(15);
                        if (hv < 10)
                            push_unit(CH_0 + 16'(hv));
                        else if ($urandom_range(1))
                            push_unit(16'("a") + 16'(hv - 10));
                        else
                            push_unit(16'("A") + 16'(hv - 10));
                    end
                end
                6, 7:
                begin
                    push_unit(CH_BACKSLASH);
                    repeat ($urandom_range(1, 4))
                        push_unit(CH_0 + 16'($urandom_range(7)));
                end
                8:
                begin
                    // mostly unknown escapes, after which the rest passes verbatim
                    push_unit(CH_BACKSLASH);
                    if ($urandom_range(1))
                        push_unit(16'($urandom_range(32, 126)));
                    else
                        push_unit(16'($urandom));
                end
                default:
                    push_unit(CH_BACKSLASH);
            endcase
        end
        ship_string();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int       target;
        board       = new();
        esc_letters = "abfnrtv\\'\"";
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        res_ready   = 1'b0;
        tx_idle_pct = 10;
        rx_idle_pct = 49;
        words_sent  = 0;
        words_in    = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 10;
                    rx_idle_pct = 49;
                end
                1:
                begin
                    tx_idle_pct = 49;
                    rx_idle_pct = 10;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            if (phase == 0)
            begin
                // extreme code units as plain text
                push_unit(16'h0000);
                push_unit(16'hFFFF);
                ship_string();
                // one hex digit cut short by a backslash, then a letter escape
                send_text("\\xf\\n");
                // hex escape with no digits, then the stopping character
                send_text("\\xG");
                // full octal escape that sign-extends
                send_text("\\377");
                // string end inside an octal escape
                send_text("\\7");
                // unknown escape, then a backslash that passes verbatim
                send_text("\\q\\");
                // trailing lone backslash gives an empty end marker
                send_text("A\\");
                send_text("\\\"");
                wait_for_drain();
            end

            target = words_sent + WORDS_A_PHASE;
            while (words_sent < target)
            begin
                send_random_string();
                if ($urandom_range(39) == 0)
                    wait_for_drain();
            end
            wait_for_drain();
        end

        $display("Sent %0d code units in random and directed strings; checked %0d result words",
                 words_in, board.results_seen);
        $display("across three flow-control phases with %0d mismatches.", board.mismatches);
        if (board.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/esd_pkg.sv
hw/rtl/esd_decode.sv
hw/rtl/escape_sequence_decoder.sv
dv/testbench.sv
